### src/lfr_pkg.sv
// Shared constants and types for the LRU frame replacement list.
package lfr_pkg;

  // Number of frames the buffer pool manages, and derived widths.
  localparam int NUM_FRAMES = 64;
  localparam int FRAME_W    = 8;
  localparam int CNT_W      = 9;
  localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int LEN_W      = $clog2(NUM_FRAMES + 1);

  // Operation codes.
  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_PIN    = 2'd1;
  localparam logic [1:0] OP_UNPIN  = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // What the cell row does in an update cycle.
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_APPEND = 2'd2;

  // Command broadcast to every cell.
  typedef struct packed {
    logic               go;
    logic [1:0]         act;
    logic [FRAME_W-1:0] frame;
  } lfr_cmd_t;

endpackage

### src/lfr_if.sv
// Request and response channel interfaces of the LRU frame replacement list.
interface lfr_req_if import lfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [FRAME_W-1:0] frame;

  modport source (output valid, output op, output frame, input ready);
  modport sink (input valid, input op, input frame, output ready);
endinterface

interface lfr_rsp_if import lfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [FRAME_W-1:0] victim_frame;
  logic [CNT_W-1:0]   evictable_count;

  modport source (output valid, output status, output victim_frame,
                  output evictable_count, input ready);
  modport sink (input valid, input status, input victim_frame,
                input evictable_count, output ready);
endinterface

### src/lfr_cell.sv
// One slot of the ordered frame list; slot 0 is the oldest entry.
module lfr_cell import lfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  lfr_cmd_t           cmd,
  input  logic               shift,
  input  logic [FRAME_W-1:0] above_frame,
  input  logic               above_valid,
  input  logic               below_valid,
  output logic [FRAME_W-1:0] frame,
  output logic               valid,
  output logic               hit
);

  // The slot holds the broadcast frame.
  assign hit = valid && (frame == cmd.frame);

  // Occupancy: filled by an append at the first free slot, refilled from above on removal.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.go) begin
      if (cmd.act == ACT_APPEND && !valid && below_valid) begin
        valid <= 1'b1;
      end else if (cmd.act == ACT_REMOVE && shift) begin
        valid <= above_valid;
      end
    end
  end

  // Payload follows the same moves.
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      if (cmd.act == ACT_APPEND && !valid && below_valid) begin
        frame <= cmd.frame;
      end else if (cmd.act == ACT_REMOVE && shift) begin
        frame <= above_frame;
      end
    end
  end

endmodule

### src/lru_frame_replacer.sv
// Top level of the LRU frame replacement list: control, flags and the cell row.
//
// The block keeps evictable frames in a row of cells ordered from oldest to newest.
// Unpin appends a frame not yet listed at the newest end. Pin removes a listed frame,
// and victim removes and returns the oldest frame. Each removal closes the gap:
// every cell at or above the removed slot takes its upper neighbor's entry. A request
// is first taken into the request registers in the idle state. In the execute state
// every cell compares its entry, the row shifts or appends, and the response is
// registered. The execute state is held for as long as an earlier response is still
// held in the output register and not yet taken. Up to one response waits in the
// output register while the next request is taken. The cells reset to empty at
// once, so no clearing pass follows reset.
module lru_frame_replacer import lfr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lfr_req_if.sink   req,
  lfr_rsp_if.source rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state;
  logic [1:0]            op_q;
  logic [FRAME_W-1:0]    frame_q;
  logic [NUM_FRAMES-1:0] listed;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      len_next;

  logic                  out_valid;
  logic [1:0]            out_status;
  logic [FRAME_W-1:0]    out_victim;
  logic [CNT_W-1:0]      out_count;

  lfr_cmd_t              cmd;
  logic                  done;
  logic                  frame_ok;
  logic                  is_listed;
  logic [1:0]            status;
  logic [FRAME_W-1:0]    victim;
  logic                  flag_we;
  logic                  flag_val;
  logic [IDX_W-1:0]      flag_idx;

  logic [FRAME_W-1:0]    cell_frame [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] cell_valid;
  logic [NUM_FRAMES-1:0] cell_hit;
  logic [NUM_FRAMES-1:0] shift_vec;

  // Handshakes.
  assign req.ready = (state == ST_IDLE);
  assign done      = (state == ST_EXEC) && (!out_valid || rsp.ready);

  // Sequencer and request capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: if (req.valid) state <= ST_EXEC;
        ST_EXEC: if (done) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q    <= req.op;
      frame_q <= req.frame;
    end
  end

  // Decode of the held request against the flags and length.
  assign frame_ok  = ({1'b0, frame_q} < (FRAME_W + 1)'(NUM_FRAMES));
  assign is_listed = frame_ok && listed[frame_q[IDX_W-1:0]];

  always_comb begin
    cmd.go    = done;
    cmd.act   = ACT_NONE;
    cmd.frame = frame_q;
    status    = STATUS_OK;
    victim    = '0;
    flag_we   = 1'b0;
    flag_val  = 1'b0;
    flag_idx  = frame_q[IDX_W-1:0];
    len_next  = len;
    case (op_q)
      OP_VICTIM: begin
        if (len == '0) begin
          status = STATUS_EMPTY;
        end else begin
          cmd.act  = ACT_REMOVE;
          victim   = cell_frame[0];
          flag_we  = 1'b1;
          flag_idx = cell_frame[0][IDX_W-1:0];
          len_next = len - LEN_W'(1);
        end
      end
      OP_PIN: begin
        if (!frame_ok) begin
          status = STATUS_INVALID;
        end else if (is_listed) begin
          cmd.act  = ACT_REMOVE;
          flag_we  = 1'b1;
          len_next = len - LEN_W'(1);
        end
      end
      OP_UNPIN: begin
        if (!frame_ok) begin
          status = STATUS_INVALID;
        end else if (!is_listed && len < LEN_W'(NUM_FRAMES)) begin
          cmd.act  = ACT_APPEND;
          flag_we  = 1'b1;
          flag_val = 1'b1;
          len_next = len + LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Listed flags and list length.
  always_ff @(posedge clk) begin
    if (rst) begin
      listed <= '0;
      len    <= '0;
    end else if (done) begin
      len <= len_next;
      if (flag_we) listed[flag_idx] <= flag_val;
    end
  end

  // Row of cells; a cell shifts when the removed slot is at or below it.
  genvar g;
  generate
    for (g = 0; g < NUM_FRAMES; g++) begin : g_cell
      logic [FRAME_W-1:0] above_frame;
      logic               above_valid;
      logic               below_valid;

      assign shift_vec[g] = (op_q == OP_VICTIM) || (|cell_hit[g:0]);

      if (g == NUM_FRAMES - 1) begin : g_top
        assign above_frame = '0;
        assign above_valid = 1'b0;
      end else begin : g_mid
        assign above_frame = cell_frame[g+1];
        assign above_valid = cell_valid[g+1];
      end

      if (g == 0) begin : g_bot
        assign below_valid = 1'b1;
      end else begin : g_up
        assign below_valid = cell_valid[g-1];
      end

      lfr_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .cmd         (cmd),
        .shift       (shift_vec[g]),
        .above_frame (above_frame),
        .above_valid (above_valid),
        .below_valid (below_valid),
        .frame       (cell_frame[g]),
        .valid       (cell_valid[g]),
        .hit         (cell_hit[g])
      );
    end
  endgenerate

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status <= status;
      out_victim <= victim;
      out_count  <= CNT_W'(len_next);
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.victim_frame    = out_victim;
  assign rsp.evictable_count = out_count;

endmodule
